// File: rtl/core/kalman_angle_bias_filter_defines.svh
// Assertion macros for the tilt Kalman filter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
`define KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define KAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KAB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/kab_pkg.sv
// Shared types and constants for the tilt Kalman filter.
// No dependencies.
`default_nettype none
package kab_pkg;
	// datapath micro-operations
	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_MUL  = 4'd1;
	localparam logic [3:0] OP_DIV  = 4'd2;
	localparam logic [3:0] OP_ADD  = 4'd3;
	localparam logic [3:0] OP_SUB  = 4'd4;
	localparam logic [3:0] OP_LOAD = 4'd5;
	// register file slots
	localparam logic [3:0] R_ANG = 4'd0;
	localparam logic [3:0] R_BIA = 4'd1;
	localparam logic [3:0] R_P0  = 4'd2;
	localparam logic [3:0] R_P1  = 4'd3;
	localparam logic [3:0] R_P2  = 4'd4;
	localparam logic [3:0] R_P3  = 4'd5;
	localparam logic [3:0] R_Z   = 4'd6;
	localparam logic [3:0] R_W   = 4'd7;
	localparam logic [3:0] R_DT  = 4'd8;
	localparam logic [3:0] R_QA  = 4'd9;
	localparam logic [3:0] R_QB  = 4'd10;
	localparam logic [3:0] R_RM  = 4'd11;
	localparam logic [3:0] R_T0  = 4'd12;
	localparam logic [3:0] R_T1  = 4'd13;
	localparam logic [3:0] R_T2  = 4'd14;
	localparam logic [3:0] R_T3  = 4'd15;
	// configuration register indexes
	localparam logic [1:0] CFG_QA = 2'd0;
	localparam logic [1:0] CFG_QB = 2'd1;
	localparam logic [1:0] CFG_RM = 2'd2;

	typedef struct packed {
		logic       start;
		logic [3:0] op;
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] dst;
		logic       force_ld;
	} kab_cmd_t;

	typedef struct packed {
		logic busy;
	} kab_sts_t;
endpackage
`default_nettype wire

// File: rtl/core/kab_datapath.sv
// Datapath: register file, shared serial multiplier/divider, saturating adder.
// Depends on kab_pkg.
`default_nettype none
`include "kalman_angle_bias_filter_defines.svh"
module kab_datapath #(
	parameter int VW = 32,
	parameter int FB = 20
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  kab_pkg::kab_cmd_t    cmd,
	output kab_pkg::kab_sts_t    sts,
	input  wire signed [VW-1:0]  z_in,
	input  wire signed [VW-1:0]  w_in,
	input  wire        [VW-2:0]  dt_in,
	input  wire                  load_in,
	input  wire        [VW-2:0]  qa,
	input  wire        [VW-2:0]  qb,
	input  wire        [VW-2:0]  rm,
	output logic signed [VW-1:0] angle,
	output logic signed [VW-1:0] bias
);
	import kab_pkg::*;
	localparam int MW = 2*VW;
	localparam int DW = VW + FB + 2;
	localparam int CW = $clog2(DW+1);
	localparam logic signed [MW+1:0] VMAX = (MW+2)'((65'sd1 <<< (VW-1)) - 1);
	localparam logic signed [MW+1:0] VMIN = -(MW+2)'(65'sd1 <<< (VW-1));

	logic signed [VW-1:0] rf_q [16];
	logic [VW-1:0]  ma_q, mb_q;
	logic           neg_q, isdiv_q, run_q, dz_q;
	logic [MW-1:0]  acc_q;
	logic [DW-1:0]  num_q, quo_q;
	logic [VW:0]    den_q;
	logic [VW+1:0]  rem_q;
	logic [CW-1:0]  cnt_q;
	logic [3:0]     dst_q;

	logic signed [VW-1:0] opa, opb;
	logic [VW-1:0] mga, mgb;
	logic signed [VW:0] sumv;
	logic [VW+1:0] remn;
	logic [MW:0] rnd;
	logic [MW:0] mres;
	logic signed [MW+1:0] sres;
	logic signed [VW-1:0] satres;

	function automatic logic [VW-1:0] fmag(input logic signed [VW-1:0] v);
		fmag = v[VW-1] ? VW'(-v) : VW'(v);
	endfunction

	assign opa = rf_q[cmd.a];
	assign opb = rf_q[cmd.b];
	assign mga = fmag(opa);
	assign mgb = fmag(opb);
	assign sts.busy = run_q;
	assign angle = rf_q[R_ANG];
	assign bias  = rf_q[R_BIA];

	// saturating add or subtract
	always_comb begin
		if (cmd.op == OP_SUB) sumv = (VW+1)'(opa) - (VW+1)'(opb);
		else sumv = (VW+1)'(opa) + (VW+1)'(opb);
	end

	// result of serial unit, rounded and saturated
	assign remn = {rem_q[VW:0], num_q[DW-1]};
	always_comb begin
		if (isdiv_q) mres = (MW+1)'(quo_q);
		else begin
			rnd = {1'b0, acc_q} + ((MW+1)'(1) << (FB-1));
			mres = rnd >> FB;
		end
		if (!isdiv_q) rnd = {1'b0, acc_q} + ((MW+1)'(1) << (FB-1));
		else rnd = '0;
		sres = neg_q ? -$signed({1'b0, mres}) : $signed({1'b0, mres});
		if (dz_q) sres = '0;
		if (sres > VMAX) satres = VMAX[VW-1:0];
		else if (sres < VMIN) satres = VMIN[VW-1:0];
		else satres = sres[VW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			for (int i = 0; i < 6; i++) rf_q[i] <= '0;
		end else begin
			rf_q[R_QA] <= $signed({1'b0, qa});
			rf_q[R_QB] <= $signed({1'b0, qb});
			rf_q[R_RM] <= $signed({1'b0, rm});
			if (load_in) begin
				rf_q[R_Z]  <= z_in;
				rf_q[R_W]  <= w_in;
				rf_q[R_DT] <= $signed({1'b0, dt_in});
			end
			if (cmd.force_ld) rf_q[R_ANG] <= rf_q[R_Z];
			if (cmd.start) begin
				case (cmd.op)
					OP_ADD, OP_SUB: begin
						if (sumv[VW] != sumv[VW-1])
							rf_q[cmd.dst] <= sumv[VW] ? VMIN[VW-1:0] : VMAX[VW-1:0];
						else rf_q[cmd.dst] <= sumv[VW-1:0];
					end
					OP_MUL: begin
						ma_q <= mga; mb_q <= mgb; acc_q <= '0;
						neg_q <= opa[VW-1] ^ opb[VW-1]; isdiv_q <= 1'b0; dz_q <= 1'b0;
						cnt_q <= CW'(VW); dst_q <= cmd.dst; run_q <= 1'b1;
					end
					OP_DIV: begin
						// numerator = (|a| << (FB+1)) + |b|, denominator 2|b|
						num_q <= (DW'(mga) << (FB+1)) + DW'(mgb);
						den_q <= {mgb, 1'b0}; rem_q <= '0; quo_q <= '0;
						neg_q <= opa[VW-1] ^ opb[VW-1]; isdiv_q <= 1'b1;
						dz_q <= (opb == '0);
						cnt_q <= CW'(DW); dst_q <= cmd.dst; run_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (run_q) begin
				if (cnt_q == '0) begin
					rf_q[dst_q] <= satres;
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
					if (isdiv_q) begin
						num_q <= num_q << 1;
						if (remn >= (VW+2)'(den_q)) begin
							rem_q <= remn - (VW+2)'(den_q);
							quo_q <= {quo_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= remn;
							quo_q <= {quo_q[DW-2:0], 1'b0};
						end
					end else begin
						// shift-add multiply, one bit per cycle
						if (mb_q[0]) acc_q <= (acc_q >> 1) + (MW'(ma_q) << (VW-1));
						else acc_q <= acc_q >> 1;
						mb_q <= mb_q >> 1;
					end
				end
			end
		end
	end

	`KAB_ASSERT_NEXT(a_start_busy, clk, arst_n,
		cmd.start && (cmd.op == OP_MUL || cmd.op == OP_DIV), sts.busy)
	`KAB_ASSERT_IMP(a_no_start_busy, clk, arst_n, sts.busy, !cmd.start)
	`KAB_ASSERT_NEXT(a_cnt_down, clk, arst_n, run_q && cnt_q != '0 && !cmd.start,
		cnt_q == $past(cnt_q) - 1'b1)
endmodule
`default_nettype wire

// File: rtl/core/kab_ctrl.sv
// Controller: sequences the micro-op program for one filter step.
// Depends on kab_pkg.
`default_nettype none
`include "kalman_angle_bias_filter_defines.svh"
module kab_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_fire,
	input  wire                force_in,
	input  wire                out_free,
	input  kab_pkg::kab_sts_t  sts,
	output kab_pkg::kab_cmd_t  cmd,
	output logic               idle,
	output logic               done
);
	import kab_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;
	localparam int NOPS = 28;

	logic [1:0] state_q;
	logic [4:0] pc_q;
	logic       force_q;
	logic [15:0] prog;

	// program: {op, a, b, dst}
	always_comb begin
		case (pc_q)
			5'd0:  prog = {OP_SUB, R_W,   R_BIA, R_T0};
			5'd1:  prog = {OP_MUL, R_DT,  R_T0,  R_T0};
			5'd2:  prog = {OP_ADD, R_ANG, R_T0,  R_ANG};
			5'd3:  prog = {OP_MUL, R_DT,  R_P3,  R_T1};
			5'd4:  prog = {OP_SUB, R_T1,  R_P1,  R_T0};
			5'd5:  prog = {OP_SUB, R_T0,  R_P2,  R_T0};
			5'd6:  prog = {OP_ADD, R_T0,  R_QA,  R_T0};
			5'd7:  prog = {OP_MUL, R_DT,  R_T0,  R_T0};
			5'd8:  prog = {OP_ADD, R_P0,  R_T0,  R_P0};
			5'd9:  prog = {OP_SUB, R_P1,  R_T1,  R_P1};
			5'd10: prog = {OP_SUB, R_P2,  R_T1,  R_P2};
			5'd11: prog = {OP_MUL, R_QB,  R_DT,  R_T0};
			5'd12: prog = {OP_ADD, R_P3,  R_T0,  R_P3};
			5'd13: prog = {OP_ADD, R_P0,  R_RM,  R_T0};
			5'd14: prog = {OP_DIV, R_P0,  R_T0,  R_T1};
			5'd15: prog = {OP_DIV, R_P2,  R_T0,  R_T2};
			5'd16: prog = {OP_SUB, R_Z,   R_ANG, R_T3};
			5'd17: prog = {OP_MUL, R_T1,  R_T3,  R_T0};
			5'd18: prog = {OP_ADD, R_ANG, R_T0,  R_ANG};
			5'd19: prog = {OP_MUL, R_T2,  R_T3,  R_T0};
			5'd20: prog = {OP_ADD, R_BIA, R_T0,  R_BIA};
			// shrink covariance; P3 and P2 first so old P0/P1 are still there
			5'd21: prog = {OP_MUL, R_T2,  R_P1,  R_T0};
			5'd22: prog = {OP_SUB, R_P3,  R_T0,  R_P3};
			5'd23: prog = {OP_MUL, R_T2,  R_P0,  R_T0};
			5'd24: prog = {OP_SUB, R_P2,  R_T0,  R_P2};
			5'd25: prog = {OP_MUL, R_T1,  R_P1,  R_T0};
			5'd26: prog = {OP_SUB, R_P1,  R_T0,  R_P1};
			5'd27: prog = {OP_MUL, R_T1,  R_P0,  R_T0};
			5'd28: prog = {OP_SUB, R_P0,  R_T0,  R_P0};
			default: prog = {OP_NOP, R_ANG, R_ANG, R_ANG};
		endcase
	end

	always_comb begin
		cmd.op = prog[15:12];
		cmd.a = prog[11:8];
		cmd.b = prog[7:4];
		cmd.dst = prog[3:0];
		cmd.start = (state_q == S_RUN) && !force_q && !sts.busy;
		cmd.force_ld = (state_q == S_RUN) && force_q;
	end
	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			force_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_RUN; pc_q <= '0; force_q <= force_in;
				end
				S_RUN: begin
					if (force_q) state_q <= S_OUT;
					else if (!sts.busy) begin
						if (pc_q == 5'(NOPS)) state_q <= S_WAIT;
						else pc_q <= pc_q + 1'b1;
					end
				end
				S_WAIT: if (!sts.busy) state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`KAB_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !sts.busy)
	`KAB_ASSERT_NEXT(a_fire_run, clk, arst_n, idle && in_fire, state_q == S_RUN)
	`KAB_ASSERT_IMP(a_start_run, clk, arst_n, cmd.start, state_q == S_RUN)
endmodule
`default_nettype wire

// File: rtl/core/kalman_angle_bias_filter.sv
// Tilt Kalman filter (angle + gyro bias), top level with APB config and output register.
// Depends on kab_pkg, kab_ctrl, kab_datapath.
// Usage:
//  Input beat: measured_angle, measured_rate, time_step, force_angle with in_valid;
//  accepted when in_valid and !in_stall. One item is worked at a time; in_stall is
//  high from acceptance until its result is handed to the output register.
//  Output beat: angle_estimate, bias_estimate with out_valid; taken when !out_stall.
//  A normal step runs 29 micro-ops: ten multiplies and two divides on one shared serial
//  unit, and seventeen adds and subtracts on the saturating adder.
//  A force step copies measured_angle into the angle estimate and skips the program.
//  A result waits in the output register while out_stall is high; the next item is
//  accepted meanwhile, and its result waits until the register frees.
//  Reset clears angle, bias and covariance and loads default noise registers.
//  Registers at byte address 0, 4, 8 over APB; write only while idle.
`default_nettype none
`include "kalman_angle_bias_filter_defines.svh"
module kalman_angle_bias_filter #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRACTION_BITS = 20
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire signed [VALUE_WIDTH-1:0] measured_angle,
	input  wire signed [VALUE_WIDTH-1:0] measured_rate,
	input  wire        [VALUE_WIDTH-2:0] time_step,
	input  wire                          force_angle,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] angle_estimate,
	output logic signed [VALUE_WIDTH-1:0] bias_estimate,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [3:0]                    paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import kab_pkg::*;
	localparam int VW = VALUE_WIDTH;
	localparam int FB = FRACTION_BITS;
	localparam logic [VW-2:0] QA_RST = (VW-1)'(((64'd1 << FB) + 64'd500) / 64'd1000);
	localparam logic [VW-2:0] QB_RST = (VW-1)'(((64'd3 << FB) + 64'd500) / 64'd1000);
	localparam logic [VW-2:0] RM_RST = (VW-1)'(((64'd3 << FB) + 64'd50) / 64'd100);

	logic [VW-2:0] qa_q, qb_q, rm_q;
	kab_cmd_t cmd;
	kab_sts_t sts;
	logic idle, done, in_fire, out_free;
	logic signed [VW-1:0] ang, bia;
	logic [63:0] pw64;

	assign pready = 1'b1;
	assign pw64 = 64'(pwdata);
	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= QA_RST; qb_q <= QB_RST; rm_q <= RM_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				CFG_QA: qa_q <= pw64[VW-2:0];
				CFG_QB: qb_q <= pw64[VW-2:0];
				CFG_RM: rm_q <= pw64[VW-2:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			CFG_QA: prdata = 32'(qa_q);
			CFG_QB: prdata = 32'(qb_q);
			CFG_RM: prdata = 32'(rm_q);
			default: prdata = '0;
		endcase
	end

	assign in_stall = !idle;
	assign in_fire = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	kab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .force_in(force_angle),
		.out_free(out_free), .sts(sts), .cmd(cmd), .idle(idle), .done(done)
	);

	kab_datapath #(.VW(VW), .FB(FB)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.z_in(measured_angle), .w_in(measured_rate), .dt_in(time_step),
		.load_in(in_fire), .qa(qa_q), .qb(qb_q), .rm(rm_q),
		.angle(ang), .bias(bia)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (done && out_free) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done && out_free) begin
			angle_estimate <= ang;
			bias_estimate <= bia;
		end
	end

	`KAB_ASSERT_IMP(a_stall_busy, clk, arst_n, !idle, in_stall)
	`KAB_ASSERT_NEXT(a_out_set, clk, arst_n, done && out_free, out_valid)
	`KAB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(angle_estimate))
endmodule
`default_nettype wire
